// ----- rtl/spd_pkg.sv -----
`timescale 1ns / 1ps

package spd_pkg;

  // Sizes of the stores.
  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;

  // Field widths.
  localparam int NODE_W   = 6;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;

  // Counter and address widths derived from the store sizes.
  localparam int NCNT_W  = $clog2(MAX_NODES + 1);
  localparam int NADDR_W = $clog2(MAX_NODES);
  localparam int EADDR_W = $clog2(MAX_EDGES);
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
  localparam int ROUND_W = $clog2(MAX_NODES);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESTINATION = 1'd1;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  // One stored edge, source in the lowest bits.
  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]          to;
    logic [NODE_W-1:0]          from;
  } edge_rec_t;

  // One distance entry: reached flag and distance.
  typedef struct packed {
    logic                     valid;
    logic signed [DIST_W-1:0] len;
  } cell_t;

  // Result of one relaxation test.
  typedef struct packed {
    logic                     improves;
    logic signed [DIST_W-1:0] sum;
  } relax_res_t;

endpackage

// ----- rtl/spd_dist_ram.sv -----
`timescale 1ns / 1ps

module spd_dist_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [spd_pkg::NADDR_W-1:0]  waddr,
  input  spd_pkg::cell_t               wdata,
  input  logic [spd_pkg::NADDR_W-1:0]  raddr_a,
  input  logic [spd_pkg::NADDR_W-1:0]  raddr_b,
  output spd_pkg::cell_t               rdata_a,
  output spd_pkg::cell_t               rdata_b
);

  spd_pkg::cell_t mem [spd_pkg::MAX_NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/spd_relax.sv -----
`timescale 1ns / 1ps

module spd_relax (
  input  spd_pkg::cell_t                       src,
  input  spd_pkg::cell_t                       dst,
  input  logic signed [spd_pkg::WEIGHT_W-1:0]  weight,
  output spd_pkg::relax_res_t                  res
);

  logic signed [spd_pkg::DIST_W:0] wide_sum;
  logic signed [spd_pkg::DIST_W-1:0] sat_sum;

  // One wide add with saturation, then one signed compare.
  always_comb begin
    wide_sum = {src.len[spd_pkg::DIST_W-1], src.len}
             + (spd_pkg::DIST_W+1)'(weight);
    if (wide_sum[spd_pkg::DIST_W] != wide_sum[spd_pkg::DIST_W-1]) begin
      sat_sum = wide_sum[spd_pkg::DIST_W] ? spd_pkg::DIST_MIN : spd_pkg::DIST_MAX;
    end else begin
      sat_sum = wide_sum[spd_pkg::DIST_W-1:0];
    end
    res.sum      = sat_sum;
    res.improves = src.valid && (!dst.valid || (sat_sum < dst.len));
  end

endmodule

// ----- rtl/shortest_path_to_destination_unit.sv -----
`timescale 1ns / 1ps
// Bellman-Ford distances to one destination node. Edge words load at one per cycle
// while the unit is idle. After the word with tlast, the run over n nodes and the
// E stored edges passes each edge through the shared adder in every round, then
// sends one result word per node, or the single negative-cycle word. New input
// waits until the last result word sits in the output register.
// Reset (rst, synchronous) empties the edge store and sets node_count 1, destination 0.

module shortest_path_to_destination_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Edge input stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,  // edge_from, edge_to, edge_weight, zeros
  input  logic                              s_tlast,  // last_edge
  // Result output stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [39:0]                       m_tdata,  // node_index, distance, reachable, zero
  output logic                              m_tuser,  // negative_cycle
  output logic                              m_tlast   // last_result
);

  // Sequencer states. Each edge visit steps through the edge store read, the
  // distance reads, and the relax/check state through the shared adder.
  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_INIT      = 10'b0000000010,
    S_COPY_RD   = 10'b0000000100,
    S_COPY_WR   = 10'b0000001000,
    S_EDGE_ADDR = 10'b0000010000,
    S_DIST_ADDR = 10'b0000100000,
    S_RELAX     = 10'b0001000000,
    S_OUT_RD    = 10'b0010000000,
    S_OUT_WR    = 10'b0100000000,
    S_NEG       = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [spd_pkg::CFG_DATA_W-1:0] node_count;
  logic [spd_pkg::NODE_W-1:0]     destination;

  // Run control.
  logic [spd_pkg::ECNT_W-1:0]  edges_loaded;
  logic [spd_pkg::ECNT_W-1:0]  k;
  logic [spd_pkg::NCNT_W-1:0]  n;
  logic [spd_pkg::NCNT_W-1:0]  j;
  logic [spd_pkg::NODE_W-1:0]  dest;
  logic [spd_pkg::ROUND_W-1:0] round_counter;
  logic                        pb;      // which distance RAM holds the previous round
  logic                        chk;     // edge pass is the negative-cycle check
  logic                        cyc;     // a negative cycle was seen

  // Output register.
  logic                        out_valid;
  logic [spd_pkg::NODE_W-1:0]  out_node;
  logic [spd_pkg::DIST_W-1:0]  out_dist;
  logic                        out_reach;
  logic                        out_neg;
  logic                        out_last;
  logic                        out_free;

  // Edge store with a registered read.
  spd_pkg::edge_rec_t edge_mem [spd_pkg::MAX_EDGES];
  spd_pkg::edge_rec_t edge_q;
  spd_pkg::edge_rec_t edge_in;

  // Distance RAM ports.
  logic                         dist_we;
  logic                         wr_to_p;
  logic [spd_pkg::NADDR_W-1:0]  dist_waddr;
  spd_pkg::cell_t               dist_wdata;
  logic [spd_pkg::NADDR_W-1:0]  addr_a;
  logic [spd_pkg::NADDR_W-1:0]  addr_b;
  spd_pkg::cell_t               rd0_a, rd0_b, rd1_a, rd1_b;
  spd_pkg::cell_t               p_a, p_b, c_b;
  spd_pkg::relax_res_t          rx;
  logic                         in_range;
  logic                         accept;
  logic [spd_pkg::NCNT_W-1:0]   n_clamped;
  logic                         last_edge_visit;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !out_valid || m_tready;

  assign edge_in.from   = s_tdata[5:0];
  assign edge_in.to     = s_tdata[11:6];
  assign edge_in.weight = s_tdata[27:12];

  // Node count 0 counts as one node; values above the store size are clamped.
  always_comb begin
    if (node_count == '0) begin
      n_clamped = spd_pkg::NCNT_W'(1);
    end else if (32'(node_count) > spd_pkg::MAX_NODES) begin
      n_clamped = spd_pkg::NCNT_W'(spd_pkg::MAX_NODES);
    end else begin
      n_clamped = spd_pkg::NCNT_W'(node_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= spd_pkg::CFG_DATA_W'(1);
      destination <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spd_pkg::CFG_NODE_COUNT:  node_count  <= cfg_data;
        spd_pkg::CFG_DESTINATION: destination <= cfg_data[spd_pkg::NODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Edge store: written while loading, read at the edge pointer every cycle.
  always_ff @(posedge clk) begin
    if (accept && (edges_loaded < spd_pkg::ECNT_W'(spd_pkg::MAX_EDGES))) begin
      edge_mem[edges_loaded[spd_pkg::EADDR_W-1:0]] <= edge_in;
    end
    edge_q <= edge_mem[k[spd_pkg::EADDR_W-1:0]];
  end

  // During an edge visit the RAMs are read at the edge endpoints; otherwise
  // port a walks the node counter.
  assign addr_a = ((state == S_DIST_ADDR) || (state == S_RELAX)) ? edge_q.to
                                                               : j[spd_pkg::NADDR_W-1:0];
  assign addr_b = edge_q.from;

  assign p_a = pb ? rd1_a : rd0_a;
  assign p_b = pb ? rd1_b : rd0_b;
  assign c_b = pb ? rd0_b : rd1_b;

  assign in_range = ({1'b0, edge_q.from} < n) && ({1'b0, edge_q.to} < n);
  assign last_edge_visit = ((k + spd_pkg::ECNT_W'(1)) == edges_loaded);

  // The shared unit: within a round the source comes from the previous round
  // and the target from the current one; the check uses the previous round twice.
  spd_relax u_relax (
    .src    (p_a),
    .dst    (chk ? p_b : c_b),
    .weight (edge_q.weight),
    .res    (rx)
  );

  always_comb begin
    dist_we    = 1'b0;
    wr_to_p    = 1'b0;
    dist_waddr = j[spd_pkg::NADDR_W-1:0];
    dist_wdata = p_a;
    case (state)
      S_INIT: begin
        dist_we          = 1'b1;
        wr_to_p          = 1'b1;
        dist_wdata.valid = (j[spd_pkg::NADDR_W-1:0] == dest);
        dist_wdata.len   = '0;
      end
      S_COPY_WR: begin
        dist_we = 1'b1;
      end
      S_RELAX: begin
        dist_we          = !chk && in_range && rx.improves;
        dist_waddr       = edge_q.from;
        dist_wdata.valid = 1'b1;
        dist_wdata.len   = rx.sum;
      end
      default: ;
    endcase
  end

  spd_dist_ram u_ram0 (
    .clk     (clk),
    .we      (dist_we && (wr_to_p ^ pb)),
    .waddr   (dist_waddr),
    .wdata   (dist_wdata),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  spd_dist_ram u_ram1 (
    .clk     (clk),
    .we      (dist_we && !(wr_to_p ^ pb)),
    .waddr   (dist_waddr),
    .wdata   (dist_wdata),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      edges_loaded  <= '0;
      k             <= '0;
      j             <= '0;
      n             <= spd_pkg::NCNT_W'(1);
      round_counter <= '0;
      pb            <= 1'b0;
      chk           <= 1'b0;
      cyc           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (edges_loaded < spd_pkg::ECNT_W'(spd_pkg::MAX_EDGES)) begin
              edges_loaded <= edges_loaded + spd_pkg::ECNT_W'(1);
            end
            if (s_tlast) begin
              n     <= n_clamped;
              dest  <= destination;
              j     <= '0;
              chk   <= 1'b0;
              cyc   <= 1'b0;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          j <= j + spd_pkg::NCNT_W'(1);
          if ((j + spd_pkg::NCNT_W'(1)) == n) begin
            j             <= '0;
            k             <= '0;
            round_counter <= spd_pkg::ROUND_W'(1);
            if (n == spd_pkg::NCNT_W'(1)) begin
              chk   <= 1'b1;
              state <= S_EDGE_ADDR;
            end else begin
              state <= S_COPY_RD;
            end
          end
        end
        S_COPY_RD: begin
          state <= S_COPY_WR;
        end
        S_COPY_WR: begin
          j     <= j + spd_pkg::NCNT_W'(1);
          state <= S_COPY_RD;
          if ((j + spd_pkg::NCNT_W'(1)) == n) begin
            j     <= '0;
            k     <= '0;
            state <= S_EDGE_ADDR;
          end
        end
        S_EDGE_ADDR: begin
          state <= S_DIST_ADDR;
        end
        S_DIST_ADDR: begin
          state <= S_RELAX;
        end
        S_RELAX: begin
          k     <= k + spd_pkg::ECNT_W'(1);
          state <= S_EDGE_ADDR;
          if (chk && in_range && rx.improves) begin
            cyc <= 1'b1;
          end
          if (last_edge_visit) begin
            k <= '0;
            j <= '0;
            if (chk) begin
              edges_loaded <= '0;
              state <= (cyc || (in_range && rx.improves)) ? S_NEG : S_OUT_RD;
            end else begin
              // The current round becomes the previous one.
              pb <= !pb;
              if ((spd_pkg::NCNT_W'(round_counter) + spd_pkg::NCNT_W'(1)) == n) begin
                chk <= 1'b1;
              end else begin
                round_counter <= round_counter + spd_pkg::ROUND_W'(1);
                state         <= S_COPY_RD;
              end
            end
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_WR;
        end
        S_OUT_WR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_node  <= j[spd_pkg::NADDR_W-1:0];
            out_dist  <= p_a.valid ? p_a.len : '0;
            out_reach <= p_a.valid;
            out_neg   <= 1'b0;
            out_last  <= ((j + spd_pkg::NCNT_W'(1)) == n);
            j         <= j + spd_pkg::NCNT_W'(1);
            state     <= ((j + spd_pkg::NCNT_W'(1)) == n) ? S_IDLE : S_OUT_RD;
          end
        end
        S_NEG: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_node  <= '0;
            out_dist  <= '0;
            out_reach <= 1'b0;
            out_neg   <= 1'b1;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_reach, out_dist, out_node};
  assign m_tuser  = out_neg;
  assign m_tlast  = out_last;

  // From the start of a run until its results go out, the store holds at least the edge that started the run.
  a_run_has_edges: assert property (@(posedge clk) disable iff (rst)
    ((state != S_IDLE) && (state != S_OUT_RD) && (state != S_OUT_WR) && (state != S_NEG))
      |-> (edges_loaded != '0))
    else $error("run in progress with an empty edge store");

  // The check pass never writes the distance RAMs.
  a_check_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_RELAX && chk) |-> !dist_we)
    else $error("distance write during negative-cycle check");

  // Every distance write lands only on a node in use.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    dist_we |-> ({1'b0, dist_waddr} < n))
    else $error("distance write beyond node count");

  // A negative-cycle word is always the last and carries no distance.
  a_neg_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_neg) |-> (out_last && !out_reach && (out_dist == '0)))
    else $error("malformed negative-cycle word");

  // Unreached nodes report distance zero.
  a_unreached_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reach) |-> (out_dist == '0))
    else $error("unreached node with nonzero distance");

endmodule

// ----- tb/shortest_path_to_destination_unit_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the Bellman-Ford destination-distance unit.
// Edge words are queued by the main initial block, pushed into the slave stream
// by a clocked driver, and each accepted word is also fed to a behavioral solver
// kept inside the bench. When a word carrying tlast is accepted, the solver runs
// the whole graph at once and queues the distance reports the unit should emit.
// A clocked monitor pops those reports as result words come out and compares them
// field by field.
module shortest_path_to_destination_unit_tb;

  // The slowest graph (64 nodes, a full edge store) computes with no handshake at
  // all, so the watchdog allows several times its compute time.
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int RANDOM_WORDS   = 50;
  localparam int CALM_AFTER     = 38;

  // One edge word as queued for the driver.
  typedef struct {
    logic [spd_pkg::NODE_W-1:0]   from_node;
    logic [spd_pkg::NODE_W-1:0]   to_node;
    logic [spd_pkg::WEIGHT_W-1:0] weight;
    logic                         last;
  } arc_word_t;

  // One distance report as the unit should send it.
  typedef struct {
    logic [spd_pkg::NODE_W-1:0]        node;
    logic signed [spd_pkg::DIST_W-1:0] length;
    logic                              reach;
    logic                              neg_cycle;
    logic                              last;
  } node_report_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index = spd_pkg::CFG_NODE_COUNT;
  logic [spd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [31:0]                    s_tdata = '0;
  logic                           s_tlast = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [39:0]                    m_tdata;
  logic                           m_tuser;
  logic                           m_tlast;

  shortest_path_to_destination_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Bench copy of the graph state and of the two registers.
  spd_pkg::edge_rec_t arc_store[spd_pkg::MAX_EDGES];
  int           arcs_held = 0;
  logic [6:0]   model_nodes = 7'd1;
  logic [5:0]   model_dest = 6'd0;

  arc_word_t    arc_feed[$];
  node_report_t expected_reports[$];
  arc_word_t    drive_word;

  int  send_gap = 0;
  int  sink_gap = 0;
  bit  calm = 1'b0;
  bit  s_took = 1'b0;
  int  quiet = 0;
  int  errors = 0;
  int  random_words = 0;
  int  graphs_solved = 0;
  int  reports_checked = 0;
  int  cycle_flags = 0;
  int  max_graph_nodes = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // The unit takes 0 as one node and anything above the store size as the store size.
  function automatic int clamp_nodes(input logic [6:0] raw);
    if (raw == 0) return 1;
    if (raw > spd_pkg::MAX_NODES) return spd_pkg::MAX_NODES;
    return int'(raw);
  endfunction

  function automatic logic signed [spd_pkg::DIST_W-1:0] sat_sum(
      input logic signed [spd_pkg::DIST_W-1:0] a,
      input logic signed [spd_pkg::WEIGHT_W-1:0] b);
    longint t;
    t = longint'(a) + longint'(b);
    if (t > longint'(spd_pkg::DIST_MAX)) return spd_pkg::DIST_MAX;
    if (t < longint'(spd_pkg::DIST_MIN)) return spd_pkg::DIST_MIN;
    return t[spd_pkg::DIST_W-1:0];
  endfunction

  // Stores an accepted edge word; on the last word of a graph, solves it and
  // queues the reports. Only the previous round's distances feed each round.
  task automatic absorb_arc(input logic [spd_pkg::NODE_W-1:0] f,
                            input logic [spd_pkg::NODE_W-1:0] t,
                            input logic signed [spd_pkg::WEIGHT_W-1:0] w, input logic last);
    int n;
    int j;
    int k;
    int r;
    bit found_cycle;
    bit reached_prev[spd_pkg::MAX_NODES];
    bit reached_cur[spd_pkg::MAX_NODES];
    logic signed [spd_pkg::DIST_W-1:0] len_prev[spd_pkg::MAX_NODES];
    logic signed [spd_pkg::DIST_W-1:0] len_cur[spd_pkg::MAX_NODES];
    logic signed [spd_pkg::DIST_W-1:0] s;
    spd_pkg::edge_rec_t a;
    node_report_t rep;

    // A full store silently drops further edges.
    if (arcs_held < spd_pkg::MAX_EDGES) begin
      arc_store[arcs_held].from = f;
      arc_store[arcs_held].to = t;
      arc_store[arcs_held].weight = w;
      arcs_held++;
    end
    if (!last) return;

    n = clamp_nodes(model_nodes);
    if (n > max_graph_nodes) max_graph_nodes = n;
    for (j = 0; j < spd_pkg::MAX_NODES; j++) begin
      reached_prev[j] = (j == int'(model_dest)) && (j < n);
      len_prev[j] = '0;
    end
    for (r = 1; r < n; r++) begin
      reached_cur = reached_prev;
      len_cur = len_prev;
      for (k = 0; k < arcs_held; k++) begin
        a = arc_store[k];
        if (a.from >= n || a.to >= n) continue;
        if (!reached_prev[a.to]) continue;
        s = sat_sum(len_prev[a.to], a.weight);
        if (!reached_cur[a.from] || s < len_cur[a.from]) begin
          reached_cur[a.from] = 1'b1;
          len_cur[a.from] = s;
        end
      end
      reached_prev = reached_cur;
      len_prev = len_cur;
    end

    // Any edge that still improves its source after n-1 rounds means a negative cycle.
    found_cycle = 1'b0;
    for (k = 0; k < arcs_held && !found_cycle; k++) begin
      a = arc_store[k];
      if (a.from >= n || a.to >= n) continue;
      if (!reached_prev[a.to]) continue;
      s = sat_sum(len_prev[a.to], a.weight);
      if (!reached_prev[a.from] || s < len_prev[a.from]) found_cycle = 1'b1;
    end
    arcs_held = 0;
    graphs_solved++;

    if (found_cycle) begin
      rep = '{node: '0, length: '0, reach: 1'b0, neg_cycle: 1'b1, last: 1'b1};
      expected_reports = {expected_reports, rep};
      return;
    end
    for (j = 0; j < n; j++) begin
      rep.node = j[spd_pkg::NODE_W-1:0];
      rep.length = reached_prev[j] ? len_prev[j] : '0;
      rep.reach = reached_prev[j];
      rep.neg_cycle = 1'b0;
      rep.last = (j == n - 1);
      expected_reports = {expected_reports, rep};
    end
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic check_report();
    node_report_t want;
    node_report_t got;
    got.node = m_tdata[5:0];
    got.length = m_tdata[37:6];
    got.reach = m_tdata[38];
    got.neg_cycle = m_tuser;
    got.last = m_tlast;
    if (expected_reports.size() == 0) begin
      note_error($sformatf("unexpected result word: node %0d length %0d reach %0b neg %0b last %0b",
                           got.node, got.length, got.reach, got.neg_cycle, got.last));
      return;
    end
    want = expected_reports.pop_front();
    reports_checked++;
    if (want.neg_cycle) cycle_flags++;
    if (got.node !== want.node || got.length !== want.length || got.reach !== want.reach ||
        got.neg_cycle !== want.neg_cycle || got.last !== want.last)
      note_error($sformatf({"result mismatch: expected node %0d length %0d reach %0b neg %0b",
                            " last %0b, got node %0d length %0d reach %0b neg %0b last %0b"},
                           want.node, want.length, want.reach, want.neg_cycle, want.last,
                           got.node, got.length, got.reach, got.neg_cycle, got.last));
  endtask

  // Slave-side driver. A word stays on the bus until the monitor has seen it
  // accepted; only then may the next one, or a short random gap, follow.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (arc_feed.size() > 0) begin
        drive_word = arc_feed.pop_front();
        s_tdata <= {4'd0, drive_word.weight, drive_word.to_node, drive_word.from_node};
        s_tlast <= drive_word.last;
        s_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 4);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Master-side back-pressure: ready drops at random while the bench is not calm.
  always @(negedge clk) begin
    if (sink_gap > 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if (!rst && !calm && $urandom_range(0, 4) == 0) sink_gap <= $urandom_range(1, 4);
    end
  end

  // Monitor: predicts on every accepted edge word, checks every accepted result
  // word, and watches for a stall with no handshake on either side.
  always @(posedge clk) begin
    if (rst) begin
      s_took <= 1'b0;
      quiet <= 0;
    end else begin
      s_took <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        absorb_arc(s_tdata[5:0], s_tdata[11:6], s_tdata[27:12], s_tlast);
      if (m_tvalid && m_tready)
        check_report();
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic queue_arc(input int f, input int t, input int w, input bit last);
    arc_word_t a;
    a.from_node = f[spd_pkg::NODE_W-1:0];
    a.to_node = t[spd_pkg::NODE_W-1:0];
    a.weight = w[spd_pkg::WEIGHT_W-1:0];
    a.last = last;
    arc_feed = {arc_feed, a};
  endtask

  // Waits until every queued word has gone in and every report has come out.
  // The unit only takes new input once its last result word sits in the output
  // register, so after this it is idle and a register write is safe.
  task automatic settle();
    do @(negedge clk);
    while (arc_feed.size() != 0 || s_tvalid || expected_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [spd_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[spd_pkg::CFG_DATA_W-1:0];
    if (idx == spd_pkg::CFG_NODE_COUNT) model_nodes = value[6:0];
    else model_dest = value[5:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small graphs; now and then the full node range or an out-of-range count.
  task automatic pick_setting();
    int r;
    int nodes;
    int dst;
    r = $urandom_range(0, 9);
    if (r == 0) nodes = spd_pkg::MAX_NODES;
    else if (r == 1) nodes = $urandom_range(0, 127);
    else nodes = $urandom_range(2, 12);
    write_reg(spd_pkg::CFG_NODE_COUNT, nodes);
    if ($urandom_range(0, 4) == 0) dst = $urandom_range(0, 63);
    else dst = $urandom_range(0, clamp_nodes(model_nodes) - 1);
    write_reg(spd_pkg::CFG_DESTINATION, dst);
  endtask

  // One well-formed graph ending in a tlast word. Endpoints mostly fall inside
  // the node range, with a few stray ones. The weight style decides whether
  // negative cycles are impossible (small, non-negative), rare (small, mostly positive) or common (full range).
  task automatic queue_random_graph(input int arcs);
    int span;
    int style;
    int k;
    int f;
    int t;
    int w;
    span = clamp_nodes(model_nodes);
    style = $urandom_range(0, 3);
    for (k = 0; k < arcs; k++) begin
      f = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, span - 1);
      t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, span - 1);
      case (style)
        0, 1: w = $urandom_range(0, 50);
        2: w = $urandom_range(0, 70) - 10;
        default: w = $urandom_range(0, 65535);
      endcase
      queue_arc(f, t, w, k == arcs - 1);
      random_words++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: a single node that is its own destination.
    queue_arc(0, 0, 0, 1'b1);
    settle();

    // Four-node chain toward node 0 with both weight extremes and edges whose
    // endpoints lie outside the node range.
    write_reg(spd_pkg::CFG_NODE_COUNT, 4);
    write_reg(spd_pkg::CFG_DESTINATION, 0);
    queue_arc(1, 0, 5, 1'b0);
    queue_arc(2, 1, -3, 1'b0);
    queue_arc(3, 2, 32767, 1'b0);
    queue_arc(63, 0, -1, 1'b0);
    queue_arc(0, 63, 7, 1'b0);
    queue_arc(2, 0, -32768, 1'b0);
    queue_arc(3, 1, 0, 1'b1);
    settle();

    // Negative cycle between nodes 0 and 1 that can reach the destination.
    write_reg(spd_pkg::CFG_NODE_COUNT, 3);
    write_reg(spd_pkg::CFG_DESTINATION, 2);
    queue_arc(0, 1, -5, 1'b0);
    queue_arc(1, 0, 2, 1'b0);
    queue_arc(0, 2, 1, 1'b1);
    settle();

    // Destination outside the node range: nothing is reachable.
    write_reg(spd_pkg::CFG_DESTINATION, 5);
    queue_arc(0, 1, 1, 1'b1);
    settle();

    // A count of zero acts as one node; a negative self-loop there is a cycle.
    write_reg(spd_pkg::CFG_NODE_COUNT, 0);
    write_reg(spd_pkg::CFG_DESTINATION, 0);
    queue_arc(0, 0, -1, 1'b1);
    settle();

    // A count above the store size is cut to the full 64 nodes; farthest destination.
    write_reg(spd_pkg::CFG_NODE_COUNT, 127);
    write_reg(spd_pkg::CFG_DESTINATION, 63);
    queue_arc(62, 63, -7, 1'b0);
    queue_arc(0, 62, 3, 1'b1);
    settle();

    // Overfill the edge store: the words past its depth are dropped, yet the
    // closing tlast word still starts the run.
    write_reg(spd_pkg::CFG_NODE_COUNT, spd_pkg::MAX_NODES);
    write_reg(spd_pkg::CFG_DESTINATION, $urandom_range(0, 63));
    for (int k = 0; k < spd_pkg::MAX_EDGES + 4; k++)
      queue_arc($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1000),
                k == spd_pkg::MAX_EDGES + 3);
    settle();

    // Random graphs. Graphs are queued back to back so gaps fall on load,
    // compute and output alike; now and then the sender waits for the unit to
    // drain completely, either to change the registers or just to hold off.
    while (random_words < RANDOM_WORDS) begin
      if (random_words >= CALM_AFTER) calm = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        settle();
        pick_setting();
      end else if ($urandom_range(0, 5) == 0) begin
        settle();
      end
      queue_random_graph($urandom_range(1, 16));
    end

    settle();
    repeat (20) @(posedge clk);
    if (expected_reports.size() != 0)
      note_error($sformatf("%0d expected result words never arrived", expected_reports.size()));

    $display("Solved %0d graphs of up to %0d nodes, including an overfilled edge store.",
             graphs_solved, max_graph_nodes);
    $display("Checked %0d result words, %0d of them negative-cycle flags; %0d errors.",
             reports_checked, cycle_flags, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
